// ----- src/csvg_pkg.sv -----
package csvg_pkg;

   localparam int SEG_MAX     = 1024;
   localparam int SEG_MIN     = 3;
   localparam int FRAC_BITS   = 14;
   localparam int CNT_W       = 11;
   localparam int IDX_W       = 10;
   localparam int VAL_W       = 16;
   localparam int SLOT_W      = 4;
   localparam int PHASE_W     = 32;

   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = PHASE_W / DIV_STEPS;

   localparam int CORDIC_ITERS  = 20;
   localparam int CORDIC_PER_ST = 2;
   localparam int CORDIC_STAGES = CORDIC_ITERS / CORDIC_PER_ST;
   localparam int XY_W          = 34;
   localparam int Z_W           = 33;
   localparam int ANG_W         = 30;
   localparam int ITER_W        = 5;
   localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032874);
   localparam int ROUND_SH      = ANG_W - FRAC_BITS;

   localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(1 << FRAC_BITS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(11);

   typedef struct packed {
      logic             valid;
      logic             bad;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] r0;
      logic [CNT_W-1:0] r1;
      logic [PHASE_W-1:0] q0;
      logic [PHASE_W-1:0] q1;
      logic             zero1;
   } div_stage_type;

   typedef struct packed {
      logic [1:0]              quad;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } cordic_lane_type;

   typedef struct packed {
      logic            valid;
      logic            bad;
      cordic_lane_type a;
      cordic_lane_type b;
   } cordic_stage_type;

   typedef struct packed {
      logic                    valid;
      logic                    bad;
      logic signed [VAL_W-1:0] x0;
      logic signed [VAL_W-1:0] z0;
      logic signed [VAL_W-1:0] x1;
      logic signed [VAL_W-1:0] z1;
   } res_type;

endpackage

// ----- src/csvg_core.sv -----
module csvg_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic                         in_bad,
   input  logic [csvg_pkg::IDX_W-1:0]   in_index,
   input  logic [csvg_pkg::CNT_W-1:0]   in_count,
   output csvg_pkg::res_type            res
);
   import csvg_pkg::*;

   div_stage_type    div_ff [DIV_STAGES];
   cordic_stage_type cor_ff [CORDIC_STAGES];
   res_type          res_ff;
   div_stage_type    div_src;

   function automatic logic [ANG_W-1:0] atan_turns(input logic [ITER_W-1:0] k);
      logic [ANG_W-1:0] v;
      unique case (k)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one restoring division bit on a remainder below n
   function automatic void div_bit(input logic [CNT_W-1:0] n,
                                   inout logic [CNT_W-1:0] r,
                                   inout logic [PHASE_W-1:0] q);
      logic [CNT_W:0] r2;
      logic           ge;
      r2 = {r, 1'b0};
      ge = r2 >= {1'b0, n};
      r  = ge ? CNT_W'(r2 - {1'b0, n}) : CNT_W'(r2);
      q  = {q[PHASE_W-2:0], ge};
   endfunction

   function automatic div_stage_type div_step(input div_stage_type d);
      div_stage_type o;
      o = d;
      for (int j = 0; j < DIV_STEPS; j++) begin
         div_bit(o.n, o.r0, o.q0);
         div_bit(o.n, o.r1, o.q1);
      end
      return o;
   endfunction

   function automatic cordic_lane_type lane_init(input logic [PHASE_W-1:0] p);
      cordic_lane_type l;
      l.quad = p[PHASE_W-1:PHASE_W-2];
      l.x    = CORDIC_K;
      l.y    = '0;
      l.z    = $signed({{(Z_W-ANG_W){1'b0}}, p[ANG_W-1:0]});
      return l;
   endfunction

   function automatic cordic_lane_type lane_iter(input cordic_lane_type l,
                                                 input int k);
      cordic_lane_type o;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  a;
      o  = l;
      dx = l.y >>> k;
      dy = l.x >>> k;
      a  = $signed({{(Z_W-ANG_W){1'b0}}, atan_turns(ITER_W'(k))});
      if (!l.z[Z_W-1]) begin
         o.x = l.x - dx;
         o.y = l.y + dy;
         o.z = l.z - a;
      end else begin
         o.x = l.x + dx;
         o.y = l.y - dy;
         o.z = l.z + a;
      end
      return o;
   endfunction

   function automatic cordic_stage_type cor_step(input cordic_stage_type c,
                                                 input int s);
      cordic_stage_type o;
      o = c;
      for (int j = 0; j < CORDIC_PER_ST; j++) begin
         o.a = lane_iter(o.a, s * CORDIC_PER_ST + j);
         o.b = lane_iter(o.b, s * CORDIC_PER_ST + j);
      end
      return o;
   endfunction

   function automatic logic signed [VAL_W-1:0] to_out(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] r;
      r = (v + XY_W'(1 << (ROUND_SH - 1))) >>> ROUND_SH;
      if (r > XY_W'(1 << FRAC_BITS))
         r = XY_W'(1 << FRAC_BITS);
      else if (r < -XY_W'(1 << FRAC_BITS))
         r = -XY_W'(1 << FRAC_BITS);
      return VAL_W'(r);
   endfunction

   function automatic void lane_out(input cordic_lane_type l,
                                    output logic signed [VAL_W-1:0] cx,
                                    output logic signed [VAL_W-1:0] sz);
      logic signed [XY_W-1:0] c;
      logic signed [XY_W-1:0] s;
      unique case (l.quad)
         2'd0: begin c = l.x;  s = l.y;  end
         2'd1: begin c = -l.y; s = l.x;  end
         2'd2: begin c = -l.x; s = -l.y; end
         2'd3: begin c = l.y;  s = -l.x; end
      endcase
      cx = to_out(c);
      sz = to_out(s);
   endfunction

   function automatic res_type finish(input cordic_stage_type c);
      res_type o;
      o.valid = c.valid;
      o.bad   = c.bad;
      lane_out(c.a, o.x0, o.z0);
      lane_out(c.b, o.x1, o.z1);
      return o;
   endfunction

   function automatic cordic_stage_type cor_init(input div_stage_type d);
      cordic_stage_type o;
      o.valid = d.valid;
      o.bad   = d.bad;
      o.a     = lane_init(d.q0);
      o.b     = lane_init(d.zero1 ? '0 : d.q1);
      return o;
   endfunction

   always_comb begin
      logic [CNT_W-1:0] i1;
      i1            = CNT_W'(in_index) + CNT_W'(1);
      div_src.valid = in_valid;
      div_src.bad   = in_bad;
      div_src.n     = in_count;
      div_src.r0    = CNT_W'(in_index);
      div_src.r1    = i1;
      div_src.q0    = '0;
      div_src.q1    = '0;
      div_src.zero1 = i1 == in_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) div_ff[s].valid <= 1'b0;
         for (int s = 0; s < CORDIC_STAGES; s++) cor_ff[s].valid <= 1'b0;
         res_ff.valid <= 1'b0;
      end else if (en) begin
         div_ff[0] <= div_step(div_src);
         for (int s = 1; s < DIV_STAGES; s++) div_ff[s] <= div_step(div_ff[s-1]);
         cor_ff[0] <= cor_step(cor_init(div_ff[DIV_STAGES-1]), 0);
         for (int s = 1; s < CORDIC_STAGES; s++) cor_ff[s] <= cor_step(cor_ff[s-1], s);
         res_ff <= finish(cor_ff[CORDIC_STAGES-1]);
      end
   end

   assign res = res_ff;

endmodule

// ----- src/cylinder_segment_vertex_gen_unit.sv -----
// an accepted request reaches the first vertex on rsp through the
// 8 division, 10 cordic, format, segment buffer and output stages, the first one
// loaded by the accepting edge; new requests enter while earlier ones are in flight
// rsp gives one vertex per cycle while not stalled, 12 per segment;
// an out-of-range index gives a single transaction on rsp
// reset: synchronous active high, empties the pipeline and sets segment_count to 3
module cylinder_segment_vertex_gen_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [csvg_pkg::CNT_W-1:0]         csr_segment_count,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [csvg_pkg::IDX_W-1:0]         req_seg_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_pos_x,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_pos_y,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_pos_z,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_norm_x,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_norm_y,
   output logic signed [csvg_pkg::VAL_W-1:0]  rsp_norm_z,
   output logic [csvg_pkg::SLOT_W-1:0]        rsp_vertex_slot,
   output logic                               rsp_bad_index,
   output logic                               rsp_last
);
   import csvg_pkg::*;

   // configuration register, always writable
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_use;
   logic             req_bad;

   // segment buffer that feeds the vertex sequencer
   res_type          core_res;
   res_type          buf_ff;
   logic             buf_valid_ff, buf_valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] px_ff, py_ff, pz_ff, nx_ff, ny_ff, nz_ff;
   logic signed [VAL_W-1:0] px_in, py_in, pz_in, nx_in, ny_in, nz_in;
   logic [SLOT_W-1:0] oslot_ff, oslot_in;
   logic             obad_ff, obad_in, olast_ff, olast_in;

   logic out_adv, take, buf_done, can_take, en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(SEG_MIN);
      end else if (csr_valid) begin
         cnt_ff <= csr_segment_count;
      end
   end

   // counts below 3 act as 3, above the maximum as the maximum
   always_comb begin
      priority if (cnt_ff < CNT_W'(SEG_MIN)) begin
         cnt_use = CNT_W'(SEG_MIN);
      end else if (cnt_ff > CNT_W'(SEG_MAX)) begin
         cnt_use = CNT_W'(SEG_MAX);
      end else begin
         cnt_use = cnt_ff;
      end
   end

   assign req_bad = CNT_W'(req_seg_index) >= cnt_use;

   // core stages move as one; a stall holds the output, and the core if a result waits
   assign out_adv  = !rsp_valid_ff || !rsp_stall;
   assign take     = buf_valid_ff && out_adv;
   assign buf_done = buf_ff.bad || (slot_ff == LAST_SLOT);
   assign can_take = !buf_valid_ff || (take && buf_done);
   assign en       = !core_res.valid || can_take;
   assign req_stall = !en;

   csvg_core u_core (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_bad   (req_bad),
      .in_index (req_seg_index),
      .in_count (cnt_use),
      .res      (core_res)
   );

   // segment buffer and slot counter
   always_comb begin
      buf_valid_in = buf_valid_ff;
      slot_in      = slot_ff;
      if (take) begin
         if (buf_done) begin
            buf_valid_in = 1'b0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
      if (en && core_res.valid) begin
         buf_valid_in = 1'b1;
         slot_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && core_res.valid) begin
         buf_ff <= core_res;
      end
   end

   // vertex of the current slot: side quad, top fan, bottom fan
   always_comb begin
      px_in = '0; py_in = '0; pz_in = '0;
      nx_in = '0; ny_in = '0; nz_in = '0;
      oslot_in = slot_ff;
      obad_in  = buf_ff.bad;
      olast_in = buf_done;
      if (buf_ff.bad) begin
         oslot_in = '0;
      end else begin
         unique case (slot_ff)
            4'd0, 4'd3: begin
               px_in = buf_ff.x0; py_in = -ONE_VAL; pz_in = buf_ff.z0;
            end
            4'd5, 4'd7: begin
               px_in = buf_ff.x0; py_in = ONE_VAL; pz_in = buf_ff.z0;
            end
            4'd11: begin
               px_in = buf_ff.x0; py_in = -ONE_VAL; pz_in = buf_ff.z0;
            end
            4'd1, 4'd10: begin
               px_in = buf_ff.x1; py_in = -ONE_VAL; pz_in = buf_ff.z1;
            end
            4'd2, 4'd4, 4'd8: begin
               px_in = buf_ff.x1; py_in = ONE_VAL; pz_in = buf_ff.z1;
            end
            4'd6: begin
               py_in = ONE_VAL;
            end
            4'd9: begin
               py_in = -ONE_VAL;
            end
            default: begin
               py_in = '0;
            end
         endcase
         // side vertices carry the rim normal, caps point along the axis
         if (slot_ff <= SLOT_W'(5)) begin
            nx_in = px_in; nz_in = pz_in;
         end else if (slot_ff <= SLOT_W'(8)) begin
            ny_in = ONE_VAL;
         end else begin
            ny_in = -ONE_VAL;
         end
      end
      rsp_valid_in = out_adv ? buf_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
         nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
         oslot_ff <= oslot_in;
         obad_ff  <= obad_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_norm_x      = nx_ff;
   assign rsp_norm_y      = ny_ff;
   assign rsp_norm_z      = nz_ff;
   assign rsp_vertex_slot = oslot_ff;
   assign rsp_bad_index   = obad_ff;
   assign rsp_last        = olast_ff;

endmodule

// ----- src/csvg_checker.sv -----
module csvg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [csvg_pkg::VAL_W-1:0]  rsp_pos_x,
   input logic signed [csvg_pkg::VAL_W-1:0]  rsp_pos_y,
   input logic signed [csvg_pkg::VAL_W-1:0]  rsp_norm_y,
   input logic [csvg_pkg::SLOT_W-1:0]        rsp_vertex_slot,
   input logic                               rsp_bad_index,
   input logic                               rsp_last
);
   import csvg_pkg::*;

   // a flagged index is a single zero transaction
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_last && rsp_vertex_slot == '0 &&
      rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_norm_y == '0)
      else $error("bad index transaction not clean");

   // vertices of one segment follow back to back in slot order
   a_slot_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
      rsp_valid && rsp_vertex_slot == $past(rsp_vertex_slot) + SLOT_W'(1))
      else $error("vertex slot sequence broken");

   // last marks slot eleven or a flagged index
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_bad_index || rsp_vertex_slot == LAST_SLOT)
      else $error("last on wrong slot");

   // a stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex_slot) &&
      $stable(rsp_pos_x))
      else $error("stalled transaction changed");

endmodule

bind cylinder_segment_vertex_gen_unit csvg_checker u_csvg_checker (.*);

// ----- test/tb_cylinder_segment_vertex_gen_unit.sv -----
`timescale 1ns / 100ps

module tb_cylinder_segment_vertex_gen_unit;
   import csvg_pkg::*;

   // one expected vertex, or the single flagged result of a bad index
   typedef struct {
      logic signed [VAL_W-1:0] px, py, pz, nx, ny, nz;
      logic [SLOT_W-1:0]       slot;
      logic                    bad, last;
   } vertex_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 300;

   // arctangent of 2^-k in 2^-32 turns
   localparam longint ATAN_TURNS [CORDIC_ITERS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};

   logic                    clock, reset;
   logic                    csr_valid, csr_ready;
   logic [CNT_W-1:0]        csr_segment_count;
   logic                    req_valid, req_stall;
   logic [IDX_W-1:0]        req_seg_index;
   logic                    rsp_valid, rsp_stall;
   logic signed [VAL_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [VAL_W-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [SLOT_W-1:0]       rsp_vertex_slot;
   logic                    rsp_bad_index, rsp_last;

   logic [IDX_W-1:0] pending_index[$];   // segment indexes waiting to be sent
   vertex_type       vertex_queue[$];    // vertices predicted and not yet seen
   logic [CNT_W-1:0] count_reg;          // our copy of segment_count
   int               fail_count;
   int               send_wait, recv_wait, hold_left;
   bit               no_idle;            // stretch without any idling
   bit               long_hold_req;
   int               quiet_cycles;

   cylinder_segment_vertex_gen_unit uut (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // round a q2.30 value to the output format and clamp to +-1.0
   function automatic logic signed [VAL_W-1:0] round_to_q14(longint v);
      longint r;
      longint one;
      one = longint'(1) << FRAC_BITS;
      r = (v + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return VAL_W'(r);
   endfunction

   // cosine and sine of a phase in 2^-32 turns via cordic
   task automatic phase_to_rim(input logic [31:0] phase,
                               output logic signed [VAL_W-1:0] cx,
                               output logic signed [VAL_W-1:0] sz);
      longint x, y, z, dx, dy, c, s;
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int k = 0; k < CORDIC_ITERS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[k];
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[k];
         end
      end
      // quadrant from the top two phase bits
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      cx = round_to_q14(c);
      sz = round_to_q14(s);
   endtask

   // queue the vertices one segment index must produce
   task automatic predict_segment(input logic [IDX_W-1:0] idx);
      longint unsigned n, i;
      logic [31:0] p0, p1;
      logic signed [VAL_W-1:0] x0, z0, x1, z1, h;
      vertex_type v;
      n = count_reg;
      i = idx;
      h = ONE_VAL;
      if (n < SEG_MIN) n = SEG_MIN;
      if (n > SEG_MAX) n = SEG_MAX;
      if (i >= n) begin
         // out of range: one flagged result, all else zero
         v = '{px: 0, py: 0, pz: 0, nx: 0, ny: 0, nz: 0, slot: 0, bad: 1, last: 1};
         vertex_queue.insert(vertex_queue.size(), v);
         return;
      end
      p0 = 32'((i << 32) / n);
      // the last segment closes the ring at exactly phase zero
      p1 = (i + 1 == n) ? 32'd0 : 32'(((i + 1) << 32) / n);
      phase_to_rim(p0, x0, z0);
      phase_to_rim(p1, x1, z1);
      for (int sl = 0; sl < 12; sl++) begin
         v.slot = SLOT_W'(sl);
         v.bad  = 1'b0;
         v.last = (sl == 11);
         case (sl)
            0, 3:  v = '{x0, -h, z0, x0, 16'sd0, z0, v.slot, 1'b0, 1'b0};
            1:     v = '{x1, -h, z1, x1, 16'sd0, z1, v.slot, 1'b0, 1'b0};
            2, 4:  v = '{x1, h, z1, x1, 16'sd0, z1, v.slot, 1'b0, 1'b0};
            5:     v = '{x0, h, z0, x0, 16'sd0, z0, v.slot, 1'b0, 1'b0};
            6:     v = '{16'sd0, h, 16'sd0, 16'sd0, h, 16'sd0, v.slot, 1'b0, 1'b0};
            7:     v = '{x0, h, z0, 16'sd0, h, 16'sd0, v.slot, 1'b0, 1'b0};
            8:     v = '{x1, h, z1, 16'sd0, h, 16'sd0, v.slot, 1'b0, 1'b0};
            9:     v = '{16'sd0, -h, 16'sd0, 16'sd0, -h, 16'sd0, v.slot, 1'b0, 1'b0};
            10:    v = '{x1, -h, z1, 16'sd0, -h, 16'sd0, v.slot, 1'b0, 1'b0};
            default: v = '{x0, -h, z0, 16'sd0, -h, 16'sd0, v.slot, 1'b0, 1'b1};
         endcase
         vertex_queue.insert(vertex_queue.size(), v);
      end
   endtask

   // ---------------------------------------------------------------
   // request driver: the head of pending_index is on the port until taken
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic fire;
      int   w;
      fire = req_valid && !req_stall;
      w    = send_wait;
      if (reset) begin
         req_valid     <= 1'b0;
         req_seg_index <= '0;
         send_wait     <= 0;
      end else begin
         if (fire) begin
            predict_segment(pending_index.pop_front());
            w = no_idle ? 0 : $urandom_range(0, 7);
         end
         // a held transaction stays on the port untouched
         if (!(req_valid && !fire)) begin
            if (w > 0) begin
               send_wait <= w - 1;
               req_valid <= 1'b0;
            end else if (pending_index.size() > 0) begin
               send_wait     <= 0;
               req_valid     <= 1'b1;
               req_seg_index <= pending_index[0];
            end else begin
               send_wait <= 0;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor and stall generator
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      vertex_type exp_v;
      int         w;
      w = recv_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected transaction slot=%0d bad=%0b", $realtime,
                        rsp_vertex_slot, rsp_bad_index);
               fail_count++;
            end else begin
               exp_v = vertex_queue.pop_front();
               if (rsp_pos_x !== exp_v.px || rsp_pos_y !== exp_v.py ||
                   rsp_pos_z !== exp_v.pz || rsp_norm_x !== exp_v.nx ||
                   rsp_norm_y !== exp_v.ny || rsp_norm_z !== exp_v.nz ||
                   rsp_vertex_slot !== exp_v.slot || rsp_bad_index !== exp_v.bad ||
                   rsp_last !== exp_v.last) begin
                  $display("%0t: expected %0d %0d %0d %0d %0d %0d slot %0d bad %0b last %0b",
                           $realtime, exp_v.px, exp_v.py, exp_v.pz, exp_v.nx, exp_v.ny,
                           exp_v.nz, exp_v.slot, exp_v.bad, exp_v.last);
                  $display("%0t: actual   %0d %0d %0d %0d %0d %0d slot %0d bad %0b last %0b",
                           $realtime, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x,
                           rsp_norm_y, rsp_norm_z, rsp_vertex_slot, rsp_bad_index, rsp_last);
                  fail_count++;
               end
            end
            w = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (long_hold_req && hold_left == 0 && rsp_valid) begin
            // back up the pipe for a long stretch
            hold_left <= LONG_HOLD;
            recv_wait <= w;
            rsp_stall <= 1'b1;
         end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            recv_wait <= w;
            rsp_stall <= 1'b1;
         end else if (w > 0) begin
            hold_left <= 0;
            recv_wait <= w - 1;
            rsp_stall <= 1'b1;
         end else begin
            hold_left <= 0;
            recv_wait <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles in a row with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------

   // wait until every index is sent and every expected vertex has come, then let the pipe settle
   task automatic drain_all();
      do @(posedge clock);
      while (pending_index.size() > 0 || vertex_queue.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_segment_count <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = value;
   endtask

   // random segment run; mostly in-range indexes, some out of range
   task automatic queue_random(input int num);
      int n;
      n = (count_reg < SEG_MIN) ? SEG_MIN : (count_reg > SEG_MAX) ? SEG_MAX : count_reg;
      for (int k = 0; k < num; k++) begin
         if ($urandom_range(0, 99) < 85)
            pending_index.insert(pending_index.size(), IDX_W'($urandom_range(0, n - 1)));
         else
            pending_index.insert(pending_index.size(), IDX_W'($urandom_range(0, 1023)));
      end
   endtask

   logic [CNT_W-1:0] count_plan[12] = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd2047,
                                        11'd1025, 11'd4, 11'd7, 11'd100, 11'd1024,
                                        11'd37, 11'd3};

   initial begin
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_segment_count = '0;
      req_valid         = 1'b0;
      req_seg_index     = '0;
      rsp_stall         = 1'b0;
      fail_count        = 0;
      quiet_cycles      = 0;
      no_idle           = 1'b0;
      long_hold_req     = 1'b0;
      count_reg         = 11'd3;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset count of three: edges, last segment, out of range
      pending_index = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023};
      drain_all();
      write_count(11'd0);
      pending_index = '{10'd0, 10'd2, 10'd3};
      drain_all();
      write_count(11'd2047);
      pending_index = '{10'd0, 10'd511, 10'd512, 10'd1023};
      drain_all();
      write_count(11'd1024);
      pending_index = '{10'd1023, 10'd767, 10'd256};
      drain_all();
      write_count(11'd5);
      pending_index = '{10'd4, 10'd5, 10'd682, 10'd341};
      drain_all();

      foreach (count_plan[p]) begin
         write_count(count_plan[p]);
         no_idle       = (p % 4 == 2);
         long_hold_req = (p == 3);
         queue_random(33);
         if (p == 3) begin
            // let the long hold land, then release
            do @(posedge clock);
            while (hold_left == 0 && pending_index.size() > 0);
            long_hold_req = 1'b0;
         end
         drain_all();
      end
      no_idle = 1'b0;
      write_count(11'($urandom_range(3, 1024)));
      queue_random(12);
      drain_all();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
